FILE: rtl/obl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package obl_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int REQ_W     = 3;
  localparam int POS_W     = 4;
  localparam int THR_W     = 8;
  localparam int BUR_W     = 10;
  localparam int LEN_W     = 16;
  localparam int REC_W     = THR_W + BUR_W + LEN_W;
  localparam int CNT_OUT_W = 5;

  // stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd4;

  typedef struct packed {
    logic [THR_W-1:0] thread;
    logic [BUR_W-1:0] burst;
    logic [LEN_W-1:0] length;
  } rec_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [POS_W-1:0] position;
    rec_t             rec;
  } req_t;

  typedef struct packed {
    logic valid;
    logic ok;
    rec_t rec;
  } resp_t;

endpackage

`default_nettype wire

FILE: rtl/obl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module obl_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/obl_step.sv
`timescale 1ns / 1ps
`default_nettype none

// shared index unit: one increment or decrement and an end-of-run compare
module obl_step #(
  parameter int W = 5
) (
  input  wire logic [W-1:0] a,
  input  wire logic         dec,
  input  wire logic [W-1:0] lim,
  output logic      [W-1:0] sum,
  output logic              hit
);

  always_comb begin
    sum = dec ? (a - W'(1)) : (a + W'(1));
    hit = (sum == lim);
  end

endmodule

`default_nettype wire

FILE: rtl/obl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module obl_ctrl #(
  parameter int LIST_DEPTH = obl_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire obl_pkg::req_t                 req,
  output obl_pkg::resp_t                     done,
  output logic [$clog2(LIST_DEPTH+1)-1:0]    count,
  input  wire logic                          out_free,
  output logic                               ram_we,
  output logic [$clog2(LIST_DEPTH)-1:0]      ram_waddr,
  output obl_pkg::rec_t                      ram_wdata,
  output logic [$clog2(LIST_DEPTH)-1:0]      ram_raddr,
  input  wire obl_pkg::rec_t                 ram_rdata
);

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = $clog2(LIST_DEPTH);
  localparam int CMP_W  = (CNT_W > obl_pkg::POS_W) ? CNT_W : obl_pkg::POS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHR_RD = 3'd1;
  localparam logic [2:0] S_SHR_WR = 3'd2;
  localparam logic [2:0] S_INS    = 3'd3;
  localparam logic [2:0] S_CAP    = 3'd4;
  localparam logic [2:0] S_RM_RD  = 3'd5;
  localparam logic [2:0] S_RM_WR  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          src_r, src_nxt;
  logic [CNT_W-1:0]          dst_r, dst_nxt;
  logic [obl_pkg::REQ_W-1:0] op_r, op_nxt;
  obl_pkg::rec_t             rec_r, rec_nxt;
  obl_pkg::rec_t             res_r, res_nxt;
  logic                      ok_r, ok_nxt;

  logic [CNT_W-1:0] unit_a, unit_sum;
  logic             unit_dec, unit_hit;
  logic [CMP_W-1:0] pos_w, cnt_w;
  logic             full, pos_ok;

  obl_step #(.W(CNT_W)) u_step (
    .a   (unit_a),
    .dec (unit_dec),
    .lim (count_r),
    .sum (unit_sum),
    .hit (unit_hit)
  );

  assign pos_w  = CMP_W'(req.position);
  assign cnt_w  = CMP_W'(count_r);
  assign full   = (count_r == CNT_W'(LIST_DEPTH));
  assign pos_ok = (pos_w < cnt_w);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    op_nxt    = op_r;
    rec_nxt   = rec_r;
    res_nxt   = res_r;
    ok_nxt    = ok_r;
    ram_we    = 1'b0;
    ram_waddr = dst_r[ADDR_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = src_r[ADDR_W-1:0];
    unit_a    = src_r;
    unit_dec  = 1'b0;

    case (state_r)
      S_IDLE: begin
        unit_a   = count_r;
        unit_dec = 1'b1;
        if (in_valid) begin
          op_nxt    = req.req_type;
          rec_nxt   = req.rec;
          ok_nxt    = 1'b0;
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (req.req_type)
            obl_pkg::REQ_PUSH: begin
              if (!full) begin
                ok_nxt  = 1'b1;
                res_nxt = req.rec;
                if (count_r == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = req.rec;
                  count_nxt = count_r + CNT_W'(1);
                end else begin
                  // move records up one slot, back to front
                  src_nxt   = unit_sum;
                  state_nxt = S_SHR_RD;
                end
              end
            end
            obl_pkg::REQ_APPEND: begin
              if (!full) begin
                ok_nxt    = 1'b1;
                res_nxt   = req.rec;
                ram_we    = 1'b1;
                ram_waddr = count_r[ADDR_W-1:0];
                ram_wdata = req.rec;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            obl_pkg::REQ_READ: begin
              if (pos_ok) begin
                ram_raddr = pos_w[ADDR_W-1:0];
                state_nxt = S_CAP;
              end
            end
            obl_pkg::REQ_POP: begin
              if (count_r != '0) begin
                ram_raddr = '0;
                src_nxt   = '0;
                state_nxt = S_CAP;
              end
            end
            obl_pkg::REQ_REMOVE: begin
              if (pos_ok) begin
                ram_raddr = pos_w[ADDR_W-1:0];
                src_nxt   = pos_w[CNT_W-1:0];
                state_nxt = S_CAP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHR_RD: begin
        dst_nxt   = unit_sum;
        state_nxt = S_SHR_WR;
      end
      S_SHR_WR: begin
        ram_we    = 1'b1;
        unit_dec  = 1'b1;
        src_nxt   = unit_sum;
        state_nxt = (src_r == '0) ? S_INS : S_SHR_RD;
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = rec_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_DONE;
      end
      S_CAP: begin
        ok_nxt  = 1'b1;
        res_nxt = ram_rdata;
        if (op_r == obl_pkg::REQ_READ) begin
          state_nxt = S_DONE;
        end else begin
          // close the gap: pull records down one slot, front to back
          src_nxt = unit_sum;
          if (unit_hit) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RM_RD;
          end
        end
      end
      S_RM_RD: begin
        unit_dec  = 1'b1;
        dst_nxt   = unit_sum;
        state_nxt = S_RM_WR;
      end
      S_RM_WR: begin
        ram_we  = 1'b1;
        src_nxt = unit_sum;
        if (unit_hit) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RM_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    dst_r <= dst_nxt;
    op_r  <= op_nxt;
    rec_r <= rec_nxt;
    res_r <= res_nxt;
    ok_r  <= ok_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign done.valid = (state_r == S_DONE);
  assign done.ok    = ok_r;
  assign done.rec   = res_r;
  assign count      = count_r;

endmodule

`default_nettype wire

FILE: rtl/ordered_burst_list.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered list of burst records (front is position 0) held in a
// single-port-read RAM and rearranged one record at a time by a small
// sequencer around one shared index increment/decrement unit. One item is
// taken at a time; in_tready is high only while the block is idle. Each
// record move costs a RAM read and a write on the next cycle, so a push to
// the front, a pop or a remove takes longer the more records it moves. A
// finished result sits in the output register and the next item is
// accepted while it waits; a further result waits until that one is taken.
module ordered_burst_list #(
  parameter int LIST_DEPTH = obl_pkg::DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // req_type[2:0]
  input  wire logic [obl_pkg::REQ_W-1:0]        in_tuser,
  // position[3:0], thread_id[11:4], burst_id[21:12], burst_length[37:22]
  input  wire logic [obl_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // ok[0]
  output logic [0:0]                            out_tuser,
  // out_thread[7:0], out_burst[17:8], out_length[33:18], entry_count[38:34],
  // is_empty[39]
  output logic [obl_pkg::OUT_DATA_W-1:0]        out_tdata
);

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = $clog2(LIST_DEPTH);

  obl_pkg::req_t   req;
  obl_pkg::resp_t  done;
  logic [CNT_W-1:0] count;
  logic            out_free;

  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
  obl_pkg::rec_t               ram_wdata, ram_rdata;
  logic [obl_pkg::REC_W-1:0]   ram_rdata_raw;

  logic                            out_tvalid_r;
  logic [0:0]                      out_tuser_r;
  logic [obl_pkg::OUT_DATA_W-1:0]  out_tdata_r;

  assign req.req_type   = in_tuser;
  assign req.position   = in_tdata[3:0];
  assign req.rec.thread = in_tdata[11:4];
  assign req.rec.burst  = in_tdata[21:12];
  assign req.rec.length = in_tdata[37:22];

  assign out_free  = !out_tvalid_r || out_tready;
  assign ram_rdata = ram_rdata_raw;

  obl_ctrl #(.LIST_DEPTH(LIST_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .req       (req),
    .done      (done),
    .count     (count),
    .out_free  (out_free),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  obl_ram #(
    .WIDTH (obl_pkg::REC_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (done.valid && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done.valid && out_free) begin
      out_tuser_r <= done.ok;
      out_tdata_r <= {(count == '0),
                      obl_pkg::CNT_OUT_W'(count),
                      done.rec.length,
                      done.rec.burst,
                      done.rec.thread};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

FILE: rtl/obl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module obl_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [0:0]                      out_tuser,
  input wire logic [obl_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a failed request carries a cleared record
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[33:0] == 34'd0)
    else $error("failed request with nonzero record");

  // the block drops in_tready after accepting an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after an accepted item");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ordered_burst_list obl_checker u_obl_checker (.*);

`default_nettype wire

FILE: tb/sv/ordered_burst_list_tb.sv
`timescale 1ns / 1ps

module ordered_burst_list_tb;

  localparam int LIST_DEPTH   = obl_pkg::DEPTH_DEF;
  localparam int RAND_ITEMS   = 420;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;
  localparam int CYCLE_LIMIT  = 300000;

  // request codes the block does not define
  localparam logic [obl_pkg::REQ_W-1:0] REQ_RSVD_LO  = 3'd5;
  localparam logic [obl_pkg::REQ_W-1:0] REQ_RSVD_MID = 3'd6;
  localparam logic [obl_pkg::REQ_W-1:0] REQ_RSVD_HI  = 3'd7;

  typedef struct packed {
    logic                          ok;
    obl_pkg::rec_t                 rec;
    logic [obl_pkg::CNT_OUT_W-1:0] count;
    logic                          empty;
  } list_resp_t;

  typedef struct {
    logic [obl_pkg::REQ_W-1:0] req;
    logic [obl_pkg::POS_W-1:0] pos;
    obl_pkg::rec_t             rec;
    int                        reps;
    bit                        typed;
    list_resp_t                resp;
  } dir_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [obl_pkg::REQ_W-1:0]      in_tuser;
  logic [obl_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [0:0]                     out_tuser;
  logic [obl_pkg::OUT_DATA_W-1:0] out_tdata;

  // shadow copy of the list
  obl_pkg::rec_t list_mem [LIST_DEPTH];
  int            list_cnt;
  list_resp_t    resp_q [$];
  dir_row_t      dir_rows [$];
  int            err_cnt;
  int            cyc;
  bit            calm_in;
  bit            calm_out;

  ordered_burst_list #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : int'($urandom_range(0, 16));
  endfunction

  function automatic obl_pkg::rec_t rand_rec();
    obl_pkg::rec_t r;
    int            sel;
    logic [31:0]   rnd;
    sel = int'($urandom_range(0, 9));
    if (sel == 0) r = '1;
    else if (sel == 1) r = '0;
    else begin
      rnd      = $urandom;
      r.thread = rnd[obl_pkg::THR_W-1:0];
      rnd      = $urandom;
      r.burst  = rnd[obl_pkg::BUR_W-1:0];
      rnd      = $urandom;
      r.length = rnd[obl_pkg::LEN_W-1:0];
    end
    return r;
  endfunction

  // apply one request to the shadow list and return what the block must answer
  task automatic list_step(input logic [obl_pkg::REQ_W-1:0] req,
                           input logic [obl_pkg::POS_W-1:0] pos,
                           input obl_pkg::rec_t rec, output list_resp_t r);
    int i;
    r = '0;
    case (req)
      obl_pkg::REQ_PUSH: begin
        if (list_cnt < LIST_DEPTH) begin
          for (i = list_cnt; i > 0; i--) list_mem[i] = list_mem[i-1];
          list_mem[0] = rec;
          list_cnt++;
          r.ok  = 1'b1;
          r.rec = rec;
        end
      end
      obl_pkg::REQ_APPEND: begin
        if (list_cnt < LIST_DEPTH) begin
          list_mem[list_cnt] = rec;
          list_cnt++;
          r.ok  = 1'b1;
          r.rec = rec;
        end
      end
      obl_pkg::REQ_READ: begin
        if (int'(pos) < list_cnt) begin
          r.ok  = 1'b1;
          r.rec = list_mem[pos];
        end
      end
      obl_pkg::REQ_POP, obl_pkg::REQ_REMOVE: begin
        // pop is a remove at the front
        if (req == obl_pkg::REQ_POP) pos = '0;
        if (int'(pos) < list_cnt) begin
          r.ok  = 1'b1;
          r.rec = list_mem[pos];
          for (i = int'(pos); i + 1 < list_cnt; i++) list_mem[i] = list_mem[i+1];
          list_cnt--;
        end
      end
      default: ;
    endcase
    r.count = list_cnt[obl_pkg::CNT_OUT_W-1:0];
    r.empty = (list_cnt == 0);
  endtask

  task automatic send_req(input logic [obl_pkg::REQ_W-1:0] req,
                          input logic [obl_pkg::POS_W-1:0] pos,
                          input obl_pkg::rec_t rec, input bit typed,
                          input list_resp_t typed_resp);
    int         gap;
    list_resp_t r;
    gap = draw_gap(calm_in);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, rec.length, rec.burst, rec.thread, pos};
    do @(posedge clk); while (!in_tready);
    list_step(req, pos, rec, r);
    resp_q.push_back(typed ? typed_resp : r);
  endtask

  task automatic add_row(input logic [obl_pkg::REQ_W-1:0] req,
                         input logic [obl_pkg::POS_W-1:0] pos,
                         input obl_pkg::rec_t rec, input int reps, input bit typed,
                         input bit ok, input int cnt);
    dir_row_t row;
    row.req        = req;
    row.pos        = pos;
    row.rec        = rec;
    row.reps       = reps;
    row.typed      = typed;
    row.resp.ok    = ok;
    row.resp.rec   = ok ? rec : '0;
    row.resp.count = cnt[obl_pkg::CNT_OUT_W-1:0];
    row.resp.empty = (cnt == 0);
    dir_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input int unsigned e, input int unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      err_cnt++;
    end
  endtask

  // stimulus
  initial begin
    int                        n_items;
    int                        mode;
    int                        sel;
    logic [31:0]               rnd;
    logic [obl_pkg::REQ_W-1:0] req;
    logic [obl_pkg::POS_W-1:0] pos;
    obl_pkg::rec_t             max_rec;
    obl_pkg::rec_t             mid_rec;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = '0;
    in_tdata  = '0;
    err_cnt   = 0;
    cyc       = 0;
    calm_in   = 1'b0;
    list_cnt  = 0;
    mode      = 0;
    max_rec   = '1;
    mid_rec   = {8'haa, 10'h155, 16'ha5a5};

    // empty list: every non-insert is refused
    add_row(obl_pkg::REQ_POP,    4'd0,  max_rec, 1, 1'b1, 1'b0, 0);
    add_row(obl_pkg::REQ_READ,   4'd0,  max_rec, 1, 1'b1, 1'b0, 0);
    add_row(obl_pkg::REQ_REMOVE, 4'd15, max_rec, 1, 1'b1, 1'b0, 0);
    add_row(REQ_RSVD_HI,         4'd0,  max_rec, 1, 1'b1, 1'b0, 0);
    add_row(obl_pkg::REQ_PUSH,   4'd15, max_rec, 1, 1'b1, 1'b1, 1);
    add_row(obl_pkg::REQ_APPEND, 4'd0,  '0,      1, 1'b1, 1'b1, 2);
    add_row(obl_pkg::REQ_READ,   4'd1,  '0,      1, 1'b0, 1'b0, 0);
    add_row(obl_pkg::REQ_READ,   4'd0,  '0,      1, 1'b0, 1'b0, 0);
    add_row(obl_pkg::REQ_REMOVE, 4'd5,  '0,      1, 1'b0, 1'b0, 0);
    add_row(obl_pkg::REQ_PUSH,   4'd0,  mid_rec, LIST_DEPTH - 2, 1'b0, 1'b0, 0);
    // full list: inserts refused
    add_row(obl_pkg::REQ_PUSH,   4'd0,  mid_rec, 1, 1'b1, 1'b0, LIST_DEPTH);
    add_row(obl_pkg::REQ_APPEND, 4'd0,  max_rec, 1, 1'b1, 1'b0, LIST_DEPTH);
    add_row(obl_pkg::REQ_READ,   4'd15, '0,      1, 1'b0, 1'b0, 0);
    add_row(REQ_RSVD_LO,         4'd3,  max_rec, 1, 1'b0, 1'b0, 0);
    add_row(REQ_RSVD_MID,        4'd9,  max_rec, 1, 1'b0, 1'b0, 0);
    add_row(obl_pkg::REQ_REMOVE, 4'd15, '0,      1, 1'b0, 1'b0, 0);
    add_row(obl_pkg::REQ_REMOVE, 4'd0,  '0,      1, 1'b0, 1'b0, 0);
    add_row(obl_pkg::REQ_POP,    4'd0,  '0,      1, 1'b0, 1'b0, 0);
    add_row(obl_pkg::REQ_READ,   4'd12, '0,      1, 1'b0, 1'b0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps)
        send_req(dir_rows[i].req, dir_rows[i].pos, dir_rows[i].rec,
                 dir_rows[i].typed, dir_rows[i].resp);
    end

    // random part: phases lean toward filling, draining or neither, so the
    // list swings between empty and full
    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      if (n_items % 30 == 0) begin
        mode    = int'($urandom_range(0, 2));
        calm_in = ($urandom_range(0, 9) < 3);
      end
      sel = int'($urandom_range(0, 99));
      if (sel < 4) begin
        rnd = $urandom_range(REQ_RSVD_LO, REQ_RSVD_HI);
        req = rnd[obl_pkg::REQ_W-1:0];
      end else begin
        sel = int'($urandom_range(0, 99));
        if (sel < (mode == 0 ? 70 : (mode == 1 ? 25 : 50)))
          req = ($urandom_range(0, 1) == 0) ? obl_pkg::REQ_PUSH : obl_pkg::REQ_APPEND;
        else begin
          sel = int'($urandom_range(0, 99));
          req = (sel < 40) ? obl_pkg::REQ_READ :
                ((sel < 65) ? obl_pkg::REQ_POP : obl_pkg::REQ_REMOVE);
        end
      end
      n_items++;
      if (list_cnt > 0 && $urandom_range(0, 99) < 85)
        rnd = $urandom_range(0, list_cnt - 1);
      else
        rnd = $urandom_range(0, 15);
      pos = rnd[obl_pkg::POS_W-1:0];
      send_req(req, pos, rand_rec(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (resp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0 && resp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side: random stalls, compare each item with the oldest expectation
  initial begin
    int         stall;
    int         n_resp;
    list_resp_t e;

    out_tready = 1'b0;
    calm_out   = 1'b0;
    n_resp     = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (n_resp % 25 == 0) calm_out = ($urandom_range(0, 9) < 3);
      stall = draw_gap(calm_out);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      n_resp++;
      if (resp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h/%0h",
                 $time, out_tuser, out_tdata);
        err_cnt++;
      end else begin
        e = resp_q.pop_front();
        check_field("ok",          e.ok,         out_tuser[0]);
        check_field("out_thread",  e.rec.thread, out_tdata[7:0]);
        check_field("out_burst",   e.rec.burst,  out_tdata[17:8]);
        check_field("out_length",  e.rec.length, out_tdata[33:18]);
        check_field("entry_count", e.count,      out_tdata[38:34]);
        check_field("is_empty",    e.empty,      out_tdata[39]);
      end
    end
  end

endmodule
